### hdl/tbac_pkg.sv
package tbac_pkg;

    localparam int MemWords = 4096;
    localparam int MemAw = $clog2(MemWords);

    typedef enum logic [2:0] {
        FUNC_EXEC  = 3'd0,
        FUNC_WRITE = 3'd1,
        FUNC_READ  = 3'd2,
        FUNC_KEY   = 3'd3,
        FUNC_SETPC = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_HALT    = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_AUTO,
        S_PTR,
        S_EA,
        S_OPER,
        S_DONE
    } t_state;

    // instruction classes, bits 11..9 of the word
    localparam logic [2:0] OpAnd = 3'd0;
    localparam logic [2:0] OpTad = 3'd1;
    localparam logic [2:0] OpIsz = 3'd2;
    localparam logic [2:0] OpDca = 3'd3;
    localparam logic [2:0] OpJms = 3'd4;
    localparam logic [2:0] OpJmp = 3'd5;
    localparam logic [2:0] OpIot = 3'd6;
    localparam logic [2:0] OpOpr = 3'd7;

    localparam logic [11:0] IotTsf = 12'o6041;
    localparam logic [11:0] IotTcf = 12'o6042;
    localparam logic [11:0] IotTpc = 12'o6044;
    localparam logic [11:0] IotTls = 12'o6046;
    localparam logic [11:0] IotIon = 12'o6001;
    localparam logic [11:0] IotIof = 12'o6002;
    localparam logic [11:0] IotKsf = 12'o6031;
    localparam logic [11:0] IotKcc = 12'o6032;
    localparam logic [11:0] IotKrs = 12'o6034;
    localparam logic [11:0] IotKrb = 12'o6036;

    typedef struct packed {
        logic        we;
        logic [11:0] waddr;
        logic [11:0] wdata;
        logic        re;
        logic [11:0] raddr;
    } t_mem_req;

endpackage

### hdl/twelve_bit_accumulator_cpu_core_unit.sv
// a write, key, set-pc or unused request is answered from the idle state; a read
// adds a read-data step; an instruction steps through fetch and decode, then as
// needed pointer read, auto-increment and operand access on the single core port
// one request in flight; the next is taken the cycle after the result is accepted
// after reset the core is swept to zero, one word a cycle, before the first
// request is taken; state registers reset to zero, ir, ea and results do not
module twelve_bit_accumulator_cpu_core_unit
    import tbac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [11:0] i_address,
    input  logic [11:0] i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_program_counter,
    output logic [11:0] o_accumulator,
    output logic        o_link,
    output logic [11:0] o_read_data,
    output logic        o_print_valid,
    output logic [6:0]  o_print_char,
    output logic [1:0]  o_interrupt_enable
);

    t_state      r_state, n_state;
    logic [MemAw:0] r_clr, n_clr;
    logic [11:0] r_sw;
    logic [11:0] r_pc, n_pc, r_ac, n_ac;
    logic        r_l, n_l, r_pf, n_pf, r_rf, n_rf;
    logic [11:0] r_key, n_key;
    logic [1:0]  r_ie, n_ie;
    logic [11:0] r_ir, n_ir, r_ea, n_ea;
    logic        r_ov, n_ov;
    logic [1:0]  r_st, n_st;
    logic [11:0] r_rd, n_rd;
    logic        r_pv, n_pv;
    logic [6:0]  r_pc7, n_pc7;
    t_mem_req    mreq;
    logic [11:0] mdata;

    logic [11:0] pa;
    logic [11:0] tail_ea;
    logic [12:0] tad;
    logic        skip;
    logic [11:0] g_ac;
    logic        g_l;
    logic [12:0] t;

    tbac_core_mem u_mem (.i_clk(i_clk), .i_req(mreq), .o_rdata(mdata));

    always_comb begin
        pa = r_ir[7] ? {r_pc[11:7], r_ir[6:0]} : {5'd0, r_ir[6:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_sw <= '0;
            r_pc <= '0; r_ac <= '0; r_l <= 1'b0; r_pf <= 1'b0; r_rf <= 1'b0;
            r_key <= '0; r_ie <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            if (i_cfg_we) r_sw <= i_cfg_wdata;
            r_pc <= n_pc; r_ac <= n_ac; r_l <= n_l; r_pf <= n_pf; r_rf <= n_rf;
            r_key <= n_key; r_ie <= n_ie; r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir <= n_ir; r_ea <= n_ea;
        r_st <= n_st; r_rd <= n_rd; r_pv <= n_pv; r_pc7 <= n_pc7;
    end

    always_comb begin
        n_state = r_state; n_clr = r_clr;
        n_pc = r_pc; n_ac = r_ac; n_l = r_l; n_pf = r_pf; n_rf = r_rf;
        n_key = r_key; n_ie = r_ie; n_ov = r_ov;
        n_ir = r_ir; n_ea = r_ea;
        n_st = r_st; n_rd = r_rd; n_pv = r_pv; n_pc7 = r_pc7;
        mreq = '0;
        tad = '0; skip = 1'b0; g_ac = r_ac; g_l = r_l; t = '0;
        // pointer word straight from memory, or the auto-incremented one
        tail_ea = (r_state == S_PTR) ? mdata : r_ea;
        if (r_ov && !i_stall) n_ov = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mreq.we = 1'b1;
                mreq.waddr = 12'(r_clr[MemAw-1:0]);
                n_clr = r_clr + 1'b1;
                if (r_clr == (MemAw + 1)'(MemWords - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid && !r_ov) begin
                    n_st = ST_OK; n_rd = '0; n_pv = 1'b0; n_pc7 = '0;
                    unique case (i_func)
                        FUNC_EXEC: begin
                            mreq.re = 1'b1; mreq.raddr = r_pc;
                            n_state = S_FETCH;
                        end
                        FUNC_READ: begin
                            mreq.re = 1'b1; mreq.raddr = i_address;
                            n_state = S_DONE;
                        end
                        FUNC_WRITE: begin
                            mreq.we = 1'b1; mreq.waddr = i_address;
                            mreq.wdata = i_data;
                            n_ov = 1'b1;
                        end
                        FUNC_KEY: begin
                            n_key = i_data; n_rf = 1'b1; n_ov = 1'b1;
                        end
                        FUNC_SETPC: begin
                            n_pc = i_data; n_ov = 1'b1;
                        end
                        default: begin
                            n_ov = 1'b1;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_ir = mdata;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                n_pc = r_pc + 12'd1;
                n_state = S_IDLE;
                if (r_ir[11:9] <= OpJmp) begin
                    n_ea = pa;
                    if (r_ir[8]) begin
                        mreq.re = 1'b1; mreq.raddr = pa;
                        n_state = (pa[11:3] == 9'd1) ? S_AUTO : S_PTR;
                    end else begin
                        unique case (r_ir[11:9])
                            OpJms: begin
                                mreq.we = 1'b1; mreq.waddr = pa; mreq.wdata = r_pc + 12'd1;
                                n_pc = pa + 12'd1; n_ov = 1'b1;
                            end
                            OpJmp: begin
                                n_pc = pa; n_ov = 1'b1;
                            end
                            OpDca: begin
                                mreq.we = 1'b1; mreq.waddr = pa; mreq.wdata = r_ac;
                                n_ac = '0; n_ov = 1'b1;
                            end
                            default: begin
                                mreq.re = 1'b1; mreq.raddr = pa; n_state = S_OPER;
                            end
                        endcase
                    end
                end else if (r_ir[11:9] == OpOpr && !r_ir[8]) begin
                    if (r_ir[7]) g_ac = '0;
                    if (r_ir[6]) g_l = 1'b0;
                    if (r_ir[5]) g_ac = ~g_ac;
                    if (r_ir[4]) g_l = ~g_l;
                    if (r_ir[0]) begin
                        t = {1'b0, g_ac} + 13'd1;
                        g_ac = t[11:0]; g_l = g_l ^ t[12];
                    end
                    if (r_ir[3]) begin
                        {g_ac, g_l} = {g_l, g_ac};
                        if (r_ir[1]) {g_ac, g_l} = {g_l, g_ac};
                    end
                    if (r_ir[2]) begin
                        {g_l, g_ac} = {g_ac, g_l};
                        if (r_ir[1]) {g_l, g_ac} = {g_ac, g_l};
                    end
                    if (r_ir[3:1] == 3'b001) g_ac = {g_ac[5:0], g_ac[11:6]};
                    n_ac = g_ac; n_l = g_l; n_ov = 1'b1;
                end else if (r_ir[11:9] == OpOpr) begin
                    skip = (r_ir[6] && r_ac[11]) || (r_ir[5] && r_ac == 12'd0)
                        || (r_ir[4] && r_l);
                    if (r_ir[3]) skip = !skip;
                    if (skip) n_pc = r_pc + 12'd2;
                    g_ac = r_ir[7] ? 12'd0 : r_ac;
                    if (r_ir[2]) g_ac = g_ac | r_sw;
                    n_ac = g_ac;
                    if (r_ir[1]) n_st = ST_HALT;
                    n_ov = 1'b1;
                end else begin
                    unique case (r_ir)
                        IotTsf: if (r_pf) n_pc = r_pc + 12'd2;
                        IotTcf: n_pf = 1'b0;
                        IotTpc, IotTls: begin
                            n_pv = (r_ac[6:0] != 7'd0);
                            n_pc7 = r_ac[6:0];
                            n_pf = 1'b1;
                        end
                        IotIon: n_ie = 2'd2;
                        IotIof: n_ie = 2'd0;
                        IotKsf: if (r_rf) n_pc = r_pc + 12'd2;
                        IotKcc: begin n_ac = '0; n_rf = 1'b0; end
                        IotKrs: n_ac = r_ac | r_key;
                        IotKrb: begin n_ac = r_key; n_rf = 1'b0; end
                        default: n_st = ST_ILLEGAL;
                    endcase
                    n_ov = 1'b1;
                end
            end
            S_AUTO: begin
                // pre-increment the auto-index word, pointer is the new value
                mreq.we = 1'b1; mreq.waddr = r_ea; mreq.wdata = mdata + 12'd1;
                n_ea = mdata + 12'd1;
                n_state = S_EA;
            end
            S_PTR, S_EA: begin
                n_ea = tail_ea;
                n_state = S_IDLE;
                unique case (r_ir[11:9])
                    OpDca: begin
                        mreq.we = 1'b1; mreq.waddr = tail_ea; mreq.wdata = r_ac;
                        n_ac = '0; n_ov = 1'b1;
                    end
                    OpJms: begin
                        mreq.we = 1'b1; mreq.waddr = tail_ea; mreq.wdata = r_pc;
                        n_pc = tail_ea + 12'd1; n_ov = 1'b1;
                    end
                    OpJmp: begin
                        n_pc = tail_ea; n_ov = 1'b1;
                    end
                    default: begin
                        mreq.re = 1'b1; mreq.raddr = tail_ea; n_state = S_OPER;
                    end
                endcase
            end
            S_OPER: begin
                unique case (r_ir[11:9])
                    OpAnd: n_ac = r_ac & mdata;
                    OpTad: begin
                        tad = {1'b0, r_ac} + {1'b0, mdata};
                        n_ac = tad[11:0];
                        n_l = r_l ^ tad[12];
                    end
                    default: begin
                        mreq.we = 1'b1; mreq.waddr = r_ea; mreq.wdata = mdata + 12'd1;
                        if (mdata == 12'o7777) n_pc = r_pc + 12'd1;
                    end
                endcase
                n_ov = 1'b1; n_state = S_IDLE;
            end
            S_DONE: begin
                n_rd = mdata; n_ov = 1'b1; n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_status = r_st;
    assign o_program_counter = r_pc;
    assign o_accumulator = r_ac;
    assign o_link = r_l;
    assign o_read_data = r_rd;
    assign o_print_valid = r_pv;
    assign o_print_char = r_pc7;
    assign o_interrupt_enable = r_ie;

`ifndef SYNTH
    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_status, o_program_counter,
            o_accumulator, o_link, o_read_data, o_print_valid, o_print_char,
            o_interrupt_enable}));

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_IDLE);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_HALT || o_status == ST_ILLEGAL));

    a_print_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_print_valid |-> o_print_char == 7'd0);
`endif

endmodule

### hdl/tbac_core_mem.sv
module tbac_core_mem
    import tbac_pkg::*;
(
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [11:0] o_rdata
);

    logic [11:0] r_mem [MemWords];
    logic [11:0] r_rdata;
    logic        r_in_range;

    // addresses at or above the store size read zero and drop writes
    always_ff @(posedge i_clk) begin
        if (i_req.we && ({20'd0, i_req.waddr} < MemWords)) begin
            r_mem[i_req.waddr[MemAw-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr[MemAw-1:0]];
            r_in_range <= ({20'd0, i_req.raddr} < MemWords);
        end
    end

    assign o_rdata = r_in_range ? r_rdata : 12'd0;

endmodule
